FILE: hdl/mws2d_pkg.sv
package mws2d_pkg;

   // field widths of the configuration registers and the result
   localparam int GRID_HEIGHT_W = 16;
   localparam int GRID_WIDTH_W  = 9;
   localparam int WIN_W         = 5;
   localparam int MAX_SUM_W     = 23;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register values after reset
   localparam int RST_GRID_HEIGHT = 10;
   localparam int RST_GRID_WIDTH  = 10;
   localparam int RST_WIN_ROWS    = 3;
   localparam int RST_WIN_COLS    = 3;

   // default sizes
   localparam int DEF_MAX_WIDTH    = 256;
   localparam int DEF_MAX_WIN_ROWS = 16;
   localparam int DEF_MAX_WIN_COLS = 16;
   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int DEF_CS_W         = 21;

   // results owed to the output side before the input is held
   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      CSR_GRID_HEIGHT = 2'd0,
      CSR_GRID_WIDTH  = 2'd1,
      CSR_WIN_ROWS    = 2'd2,
      CSR_WIN_COLS    = 2'd3
   } csr_index_type;

   // per-word control that travels down the pipeline with the sample
   typedef struct packed {
      logic row0;   // first row of the grid
      logic sub;    // drop the sample that left the window column
      logic hact;   // row completes a full window height
      logic c0;     // first column
      logic csub;   // drop the column sum that left the window
      logic elig;   // window lies fully inside the row
      logic first;  // first cell of the grid
      logic last;   // last cell of the grid
   } item_flags_type;

endpackage

FILE: hdl/max_window_sum_2d.sv
// channel | ports                                      | word
// --------+--------------------------------------------+---------------------------
// input   | req_valid, req_stall, req_sample            | one grid cell, raster order
// output  | rsp_valid, rsp_stall, rsp_max_sum           | best window sum of a grid
// config  | psel, penable, pwrite, paddr, pwdata, prdata| 4 registers at 4*index
//
// One sample is taken every clock while req_stall is low; the column-sum memory port
// with a one-word forward closes a read-modify-write per sample, which sets that rate.
// A grid's result passes the line-sum s1 and output registers, s3 and the result queue.
// req_stall rises only while 4 result words are owed and the next sample ends a grid.
// Synchronous reset, no clearing pass: the first row of a grid bypasses the column sums.
module max_window_sum_2d #(
   parameter int MAX_WIDTH    = mws2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WIN_ROWS = mws2d_pkg::DEF_MAX_WIN_ROWS,
   parameter int MAX_WIN_COLS = mws2d_pkg::DEF_MAX_WIN_COLS,
   parameter int SAMPLE_BITS  = mws2d_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mws2d_pkg::MAX_SUM_W-1:0]     rsp_max_sum,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mws2d_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mws2d_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mws2d_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
   localparam int CS_W  = SAMPLE_BITS + $clog2(MAX_WIN_ROWS + 1);
   localparam int TOT_W = CS_W + $clog2(MAX_WIN_COLS + 1);
   localparam int LW    = (COL_W + 1 > mws2d_pkg::GRID_WIDTH_W) ? COL_W + 1
                                                              : mws2d_pkg::GRID_WIDTH_W;
   localparam int QP_W  = $clog2(mws2d_pkg::RSP_DEPTH);
   localparam int QC_W  = $clog2(mws2d_pkg::RSP_DEPTH + 1);
   localparam int HW    = mws2d_pkg::GRID_HEIGHT_W;

   // configuration registers
   logic [HW-1:0]                       grid_height_ff;
   logic [mws2d_pkg::GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [mws2d_pkg::WIN_W-1:0]         win_rows_ff;
   logic [mws2d_pkg::WIN_W-1:0]         win_cols_ff;
   logic                                cfg_wr;
   mws2d_pkg::csr_index_type            csr_idx;

   // raster position
   logic [HW-1:0]                       row_ff;
   logic [COL_W-1:0]                    col_ff;
   logic [ROW_W-1:0]                    wp_ff;
   logic [ROW_W-1:0]                    rd_slot;

   logic [HW-1:0]                       h_last;
   logic [LW-1:0]                       gw_ext;
   logic [LW-1:0]                       w_eff;
   logic [LW-1:0]                       w_last;
   logic                                col_last;
   logic                                row_last;
   logic                                fits;
   logic                                accept;
   logic                                next_last;
   mws2d_pkg::item_flags_type           in_flags;

   // window stage
   logic                                s2_valid;
   mws2d_pkg::item_flags_type           s2_flags;
   logic signed [CS_W-1:0]              s2_cs;
   logic signed [CS_W-1:0]              cell_val [MAX_WIN_COLS];
   logic signed [CS_W-1:0]              cell_tap [MAX_WIN_COLS];
   logic signed [CS_W-1:0]              tap;
   logic                                win_shift;
   logic signed [TOT_W-1:0]             total_ff;
   logic signed [TOT_W-1:0]             total_in;

   // best-sum stage
   logic                                s3_valid_ff;
   mws2d_pkg::item_flags_type           s3_flags_ff;
   logic signed [TOT_W-1:0]             s3_total_ff;
   logic signed [TOT_W-1:0]             best_ff;
   logic signed [TOT_W-1:0]             best_base;
   logic signed [TOT_W-1:0]             best_in;
   logic                                push;

   // result queue
   logic [mws2d_pkg::MAX_SUM_W-1:0]     q_mem [mws2d_pkg::RSP_DEPTH];
   logic [QP_W-1:0]                     q_wr_ff;
   logic [QP_W-1:0]                     q_rd_ff;
   logic [QC_W-1:0]                     q_cnt_ff;
   logic [QC_W-1:0]                     pending_ff;
   logic                                pop;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite & pready;
   assign csr_idx = mws2d_pkg::csr_index_type'(paddr[mws2d_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_height_ff <= HW'(mws2d_pkg::RST_GRID_HEIGHT);
         grid_width_ff  <= mws2d_pkg::GRID_WIDTH_W'(mws2d_pkg::RST_GRID_WIDTH);
         win_rows_ff    <= mws2d_pkg::WIN_W'(mws2d_pkg::RST_WIN_ROWS);
         win_cols_ff    <= mws2d_pkg::WIN_W'(mws2d_pkg::RST_WIN_COLS);
      end else if (cfg_wr) begin
         case (csr_idx)
            mws2d_pkg::CSR_GRID_HEIGHT: grid_height_ff <= pwdata[HW-1:0];
            mws2d_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= pwdata[mws2d_pkg::GRID_WIDTH_W-1:0];
            mws2d_pkg::CSR_WIN_ROWS:    win_rows_ff    <= pwdata[mws2d_pkg::WIN_W-1:0];
            mws2d_pkg::CSR_WIN_COLS:    win_cols_ff    <= pwdata[mws2d_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mws2d_pkg::CSR_GRID_HEIGHT: prdata = mws2d_pkg::CSR_DATA_W'(grid_height_ff);
         mws2d_pkg::CSR_GRID_WIDTH:  prdata = mws2d_pkg::CSR_DATA_W'(grid_width_ff);
         mws2d_pkg::CSR_WIN_ROWS:    prdata = mws2d_pkg::CSR_DATA_W'(win_rows_ff);
         mws2d_pkg::CSR_WIN_COLS:    prdata = mws2d_pkg::CSR_DATA_W'(win_cols_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------- raster position and per-word flags ----------------
   always_comb begin
      h_last = (grid_height_ff == '0) ? '0 : grid_height_ff - HW'(1);
      gw_ext = LW'(grid_width_ff);
      if (gw_ext == '0) begin
         w_eff = LW'(1);
      end else if (gw_ext > LW'(MAX_WIDTH)) begin
         w_eff = LW'(MAX_WIDTH);
      end else begin
         w_eff = gw_ext;
      end
      w_last    = w_eff - LW'(1);
      col_last  = (LW'(col_ff) == w_last);
      row_last  = (row_ff == h_last);
      next_last = col_last & row_last;
      fits = (win_rows_ff != '0) && (int'(win_rows_ff) <= MAX_WIN_ROWS) &&
             (win_cols_ff != '0) && (int'(win_cols_ff) <= MAX_WIN_COLS);

      in_flags.row0  = (row_ff == '0);
      in_flags.sub   = fits && (int'(row_ff) >= int'(win_rows_ff));
      in_flags.hact  = fits && (int'(row_ff) + 1 >= int'(win_rows_ff));
      in_flags.c0    = (col_ff == '0);
      in_flags.csub  = (int'(col_ff) >= int'(win_cols_ff));
      in_flags.elig  = (int'(col_ff) + 1 >= int'(win_cols_ff));
      in_flags.first = (row_ff == '0) && (col_ff == '0);
      in_flags.last  = next_last;

      // ring row that leaves the window
      if (int'(wp_ff) >= int'(win_rows_ff)) begin
         rd_slot = ROW_W'(int'(wp_ff) - int'(win_rows_ff));
      end else begin
         rd_slot = ROW_W'(int'(wp_ff) + MAX_WIN_ROWS - int'(win_rows_ff));
      end
   end

   // hold the input only when the next word ends a grid and the queue has no room left
   assign req_stall = next_last && (pending_ff == QC_W'(mws2d_pkg::RSP_DEPTH));
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         row_ff <= '0;
         col_ff <= '0;
         wp_ff  <= '0;
      end else if (accept) begin
         if (col_last) begin
            col_ff <= '0;
            if (row_last) begin
               row_ff <= '0;
               wp_ff  <= '0;
            end else begin
               row_ff <= row_ff + HW'(1);
               wp_ff  <= (int'(wp_ff) == MAX_WIN_ROWS - 1) ? '0 : wp_ff + ROW_W'(1);
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // ---------------- column sums over the line ring ----------------
   mws2d_line_sum #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_WIN_ROWS (MAX_WIN_ROWS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_line_sum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_flags   (in_flags),
      .in_col     (col_ff),
      .in_wr_slot (wp_ff),
      .in_rd_slot (rd_slot),
      .in_sample  (req_sample),
      .out_valid  (s2_valid),
      .out_flags  (s2_flags),
      .out_cs     (s2_cs)
   );

   // ---------------- row of window cells ----------------
   assign win_shift = s2_valid & s2_flags.hact;

   for (genvar k = 0; k < MAX_WIN_COLS; k++) begin : g_cell
      mws2d_win_cell #(
         .DATA_W (CS_W)
      ) u_cell (
         .clock   (clock),
         .shift   (win_shift),
         .sel     (int'(win_cols_ff) == k + 1),
         .d_in    ((k == 0) ? s2_cs : cell_val[(k == 0) ? 0 : k - 1]),
         .d_out   (cell_val[k]),
         .tap_out (cell_tap[k])
      );
   end

   always_comb begin
      tap = '0;
      for (int k = 0; k < MAX_WIN_COLS; k++) begin
         tap = tap | cell_tap[k];
      end
      total_in = (s2_flags.c0 ? TOT_W'(0) : total_ff) + TOT_W'(s2_cs)
               - (s2_flags.csub ? TOT_W'(tap) : TOT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (win_shift) begin
         total_ff <= total_in;
      end
      s3_total_ff <= total_in;
      s3_flags_ff <= s2_flags;
   end

   // ---------------- best sum ----------------
   always_comb begin
      best_base = s3_flags_ff.first ? TOT_W'(0) : best_ff;
      if (s3_flags_ff.hact && s3_flags_ff.elig && (s3_total_ff > best_base)) begin
         best_in = s3_total_ff;
      end else begin
         best_in = best_base;
      end
   end

   assign push = s3_valid_ff & s3_flags_ff.last;

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         best_ff <= best_in;
      end
      if (push) begin
         q_mem[q_wr_ff] <= mws2d_pkg::MAX_SUM_W'($unsigned(best_in));
      end
   end

   // ---------------- result queue ----------------
   assign rsp_valid   = (q_cnt_ff != '0);
   assign rsp_max_sum = q_mem[q_rd_ff];
   assign pop         = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         q_wr_ff     <= '0;
         q_rd_ff     <= '0;
         q_cnt_ff    <= '0;
         pending_ff  <= '0;
      end else begin
         s3_valid_ff <= s2_valid;
         if (push) begin
            q_wr_ff <= q_wr_ff + QP_W'(1);
         end
         if (pop) begin
            q_rd_ff <= q_rd_ff + QP_W'(1);
         end
         q_cnt_ff   <= q_cnt_ff + QC_W'(push) - QC_W'(pop);
         pending_ff <= pending_ff + QC_W'(accept & next_last) - QC_W'(pop);
      end
   end

endmodule

FILE: hdl/mws2d_line_sum.sv
module mws2d_line_sum #(
   parameter int MAX_WIDTH    = mws2d_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WIN_ROWS = mws2d_pkg::DEF_MAX_WIN_ROWS,
   parameter int SAMPLE_BITS  = mws2d_pkg::DEF_SAMPLE_BITS,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int ROW_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1,
   localparam int CS_W  = SAMPLE_BITS + $clog2(MAX_WIN_ROWS + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  mws2d_pkg::item_flags_type        in_flags,
   input  logic [COL_W-1:0]                 in_col,
   input  logic [ROW_W-1:0]                 in_wr_slot,
   input  logic [ROW_W-1:0]                 in_rd_slot,
   input  logic signed [SAMPLE_BITS-1:0]    in_sample,
   output logic                             out_valid,
   output mws2d_pkg::item_flags_type        out_flags,
   output logic signed [CS_W-1:0]           out_cs
);

   logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WIN_ROWS][MAX_WIDTH];
   logic signed [CS_W-1:0]        col_mem [MAX_WIDTH];

   logic signed [SAMPLE_BITS-1:0] ring_rd_ff;
   logic signed [CS_W-1:0]        col_rd_ff;
   logic                          fwd_hit_ff;
   logic signed [CS_W-1:0]        fwd_data_ff;

   logic                          s1_valid_ff;
   mws2d_pkg::item_flags_type     s1_flags_ff;
   logic [COL_W-1:0]              s1_col_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;

   logic                          out_valid_ff;
   mws2d_pkg::item_flags_type     out_flags_ff;
   logic signed [CS_W-1:0]        out_cs_ff;

   logic signed [CS_W-1:0]        cs_base;
   logic signed [CS_W-1:0]        cs_in;

   // line ring: read the row that leaves the window, write the new sample
   always_ff @(posedge clock) begin
      ring_rd_ff <= ring_mem[in_rd_slot][in_col];
      if (in_valid) begin
         ring_mem[in_wr_slot][in_col] <= in_sample;
      end
   end

   // column sums: read at accept, write back in the cycle after
   always_ff @(posedge clock) begin
      col_rd_ff <= col_mem[in_col];
      if (s1_valid_ff) begin
         col_mem[s1_col_ff] <= cs_in;
      end
   end

   always_comb begin
      // first row starts every column from zero; forward a write still in flight
      if (s1_flags_ff.row0) begin
         cs_base = '0;
      end else if (fwd_hit_ff) begin
         cs_base = fwd_data_ff;
      end else begin
         cs_base = col_rd_ff;
      end
      cs_in = cs_base + CS_W'(s1_sample_ff)
            - (s1_flags_ff.sub ? CS_W'(ring_rd_ff) : CS_W'(0));
   end

   always_ff @(posedge clock) begin
      fwd_hit_ff   <= s1_valid_ff && (s1_col_ff == in_col);
      fwd_data_ff  <= cs_in;
      s1_flags_ff  <= in_flags;
      s1_col_ff    <= in_col;
      s1_sample_ff <= in_sample;
      out_flags_ff <= s1_flags_ff;
      out_cs_ff    <= cs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_flags = out_flags_ff;
   assign out_cs    = out_cs_ff;

endmodule

FILE: hdl/mws2d_win_cell.sv
module mws2d_win_cell #(
   parameter int DATA_W = mws2d_pkg::DEF_CS_W
) (
   input  logic                     clock,
   input  logic                     shift,
   input  logic                     sel,
   input  logic signed [DATA_W-1:0] d_in,
   output logic signed [DATA_W-1:0] d_out,
   output logic signed [DATA_W-1:0] tap_out
);

   logic signed [DATA_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= d_in;
      end
   end

   assign d_out   = value_ff;
   assign tap_out = sel ? value_ff : '0;

endmodule

FILE: hdl/mws2d_checker.sv
module mws2d_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [mws2d_pkg::MAX_SUM_W-1:0]   rsp_max_sum,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [mws2d_pkg::CSR_ADDR_W-1:0]  paddr,
   input logic [mws2d_pkg::CSR_DATA_W-1:0]  pwdata,
   input logic [mws2d_pkg::CSR_DATA_W-1:0]  prdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_sum))
      else $error("result word changed while stalled");

   // no result word is owed right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // the input holds only while result words wait at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input held with no result word waiting");

   // a written grid height reads back
   a_height_rb: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite &&
      (paddr[mws2d_pkg::CSR_ADDR_W-1:2] == mws2d_pkg::CSR_GRID_HEIGHT)
      ##1 (paddr[mws2d_pkg::CSR_ADDR_W-1:2] == mws2d_pkg::CSR_GRID_HEIGHT)
      |-> prdata == mws2d_pkg::CSR_DATA_W'($past(pwdata[mws2d_pkg::GRID_HEIGHT_W-1:0])))
      else $error("grid height read back wrong");

   // an offered word is never held while a result word waits, right after reset
   a_req_quiet: assert property (@(posedge clock)
      reset |=> !(req_valid && req_stall && rsp_valid))
      else $error("input held right after reset");

endmodule

bind max_window_sum_2d mws2d_checker u_mws2d_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_max_sum (rsp_max_sum),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);

FILE: tb/testbench.sv
module testbench;

   typedef enum int {FILL_MIXED, FILL_MAX, FILL_MIN} fill_kind_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [15:0]                     req_sample = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [mws2d_pkg::MAX_SUM_W-1:0]        rsp_max_sum;
   logic                                   psel = 1'b0;
   logic                                   penable = 1'b0;
   logic                                   pwrite = 1'b0;
   logic [mws2d_pkg::CSR_ADDR_W-1:0]       paddr = '0;
   logic [mws2d_pkg::CSR_DATA_W-1:0]       pwdata = '0;
   logic [mws2d_pkg::CSR_DATA_W-1:0]       prdata;
   logic                                   pready;

   // register copies and grid state of the window-sum predictor
   logic [mws2d_pkg::GRID_HEIGHT_W-1:0]    cfg_height;
   logic [mws2d_pkg::GRID_WIDTH_W-1:0]     cfg_width;
   logic [mws2d_pkg::WIN_W-1:0]            cfg_win_rows;
   logic [mws2d_pkg::WIN_W-1:0]            cfg_win_cols;
   logic signed [15:0]                     line_store
                                           [mws2d_pkg::DEF_MAX_WIN_ROWS*mws2d_pkg::DEF_MAX_WIDTH];
   logic signed [mws2d_pkg::DEF_CS_W-1:0]  col_total [mws2d_pkg::DEF_MAX_WIDTH];
   logic signed [mws2d_pkg::DEF_CS_W-1:0]  recent_cols [mws2d_pkg::DEF_MAX_WIN_COLS];
   logic signed [24:0]                     win_sum;
   logic signed [23:0]                     best;
   logic [15:0]                            cur_row;
   logic [7:0]                             cur_col;

   logic signed [15:0]                     cell_queue [$];
   logic [mws2d_pkg::MAX_SUM_W-1:0]        expected_sums [$];
   logic [mws2d_pkg::MAX_SUM_W-1:0]        want;
   int                                     mismatch_count = 0;
   int                                     send_gap = 0;
   int                                     stall_left = 0;
   int                                     open_left = 0;
   int                                     hold_left = 0;
   int                                     hold_requests = 0;
   int                                     hold_served = 0;
   bit                                     calm = 1'b0;

   max_window_sum_2d uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_max_sum (rsp_max_sum),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void reset_model();
      cfg_height   = mws2d_pkg::GRID_HEIGHT_W'(mws2d_pkg::RST_GRID_HEIGHT);
      cfg_width    = mws2d_pkg::GRID_WIDTH_W'(mws2d_pkg::RST_GRID_WIDTH);
      cfg_win_rows = mws2d_pkg::WIN_W'(mws2d_pkg::RST_WIN_ROWS);
      cfg_win_cols = mws2d_pkg::WIN_W'(mws2d_pkg::RST_WIN_COLS);
      foreach (line_store[i]) line_store[i] = '0;
      foreach (col_total[i]) col_total[i] = '0;
      foreach (recent_cols[i]) recent_cols[i] = '0;
      win_sum = '0;
      best    = '0;
      cur_row = '0;
      cur_col = '0;
   endfunction

   function automatic void predict_cell(input logic signed [15:0] s);
      int  h, w, r, c, wr, wc, cs;
      bit  fits;
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      w = (cfg_width == 0) ? 1 : int'(cfg_width);
      if (w > mws2d_pkg::DEF_MAX_WIDTH) w = mws2d_pkg::DEF_MAX_WIDTH;
      r = int'(cur_row);
      c = int'(cur_col);
      if (c >= w) c = w - 1;
      wr = int'(cfg_win_rows);
      wc = int'(cfg_win_cols);
      fits = wr >= 1 && wr <= mws2d_pkg::DEF_MAX_WIN_ROWS &&
             wc >= 1 && wc <= mws2d_pkg::DEF_MAX_WIN_COLS;

      if (r == 0 && c == 0) begin
         foreach (col_total[i]) col_total[i] = '0;
         foreach (recent_cols[i]) recent_cols[i] = '0;
         win_sum = '0;
         best    = '0;
      end

      // column sum over the last wr rows
      col_total[c] = col_total[c] + mws2d_pkg::DEF_CS_W'(s);
      if (fits && r >= wr)
         col_total[c] = col_total[c] - mws2d_pkg::DEF_CS_W'(
            line_store[((r - wr) % mws2d_pkg::DEF_MAX_WIN_ROWS) * mws2d_pkg::DEF_MAX_WIDTH + c]);
      line_store[(r % mws2d_pkg::DEF_MAX_WIN_ROWS) * mws2d_pkg::DEF_MAX_WIDTH + c] = s;

      // window sum over the last wc column sums
      if (fits && r + 1 >= wr) begin
         cs = int'(col_total[c]);
         if (c == 0) win_sum = '0;
         win_sum = win_sum + 25'(cs);
         if (c >= wc)
            win_sum = win_sum - 25'(recent_cols[(c - wc) % mws2d_pkg::DEF_MAX_WIN_COLS]);
         recent_cols[c % mws2d_pkg::DEF_MAX_WIN_COLS] = mws2d_pkg::DEF_CS_W'(cs);
         if (c + 1 >= wc && win_sum > 25'(best)) best = 24'(win_sum);
      end

      if (c + 1 >= w) begin
         cur_col = '0;
         if (r + 1 >= h) begin
            cur_row = '0;
            expected_sums.push_back(best[mws2d_pkg::MAX_SUM_W-1:0]);
         end else begin
            cur_row = 16'(r + 1);
         end
      end else begin
         cur_col = 8'(c + 1);
         cur_row = 16'(r);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm) return 0;
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [15:0] next_sample(input fill_kind_type fill);
      int roll;
      roll = $urandom_range(0, 9);
      case (fill)
         FILL_MAX: return 16'sh7FFF;
         FILL_MIN: return 16'sh8000;
         default: begin
            if (roll == 0) return 16'sh7FFF;
            if (roll == 1) return 16'sh8000;
            if (roll == 2) return 16'($urandom_range(0, 200) - 100);
            return 16'($urandom());
         end
      endcase
   endfunction

   function automatic int pick_win(input int span);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6)
         return $urandom_range(1, (span > mws2d_pkg::DEF_MAX_WIN_ROWS) ?
                                  mws2d_pkg::DEF_MAX_WIN_ROWS : span);
      if (roll < 8) return $urandom_range(1, mws2d_pkg::DEF_MAX_WIN_ROWS);
      if (roll == 8) return $urandom_range(0, 31);
      return mws2d_pkg::DEF_MAX_WIN_ROWS;
   endfunction

   // input side: issue words from the queue, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) predict_cell(req_sample);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cell_queue.size() > 0) begin
               req_sample <= cell_queue.pop_front();
               req_valid  <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // output side: check each accepted word, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               $error("max_sum: expected none, actual %0d", rsp_max_sum);
               mismatch_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_max_sum !== want) begin
                  $error("max_sum: expected %0d, actual %0d", want, rsp_max_sum);
                  mismatch_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_left = pick_gap();
            open_left = calm ? 50 : $urandom_range(0, 16);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input mws2d_pkg::csr_index_type idx, input int value);
      int          fw;
      logic [31:0] word;
      case (idx)
         mws2d_pkg::CSR_GRID_HEIGHT: fw = mws2d_pkg::GRID_HEIGHT_W;
         mws2d_pkg::CSR_GRID_WIDTH:  fw = mws2d_pkg::GRID_WIDTH_W;
         default:                    fw = mws2d_pkg::WIN_W;
      endcase
      // random bits above the field must be ignored
      word = ($urandom() << fw) | (32'(value) & ((32'd1 << fw) - 32'd1));
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         mws2d_pkg::CSR_GRID_HEIGHT: cfg_height   = word[mws2d_pkg::GRID_HEIGHT_W-1:0];
         mws2d_pkg::CSR_GRID_WIDTH:  cfg_width    = word[mws2d_pkg::GRID_WIDTH_W-1:0];
         mws2d_pkg::CSR_WIN_ROWS:    cfg_win_rows = word[mws2d_pkg::WIN_W-1:0];
         mws2d_pkg::CSR_WIN_COLS:    cfg_win_cols = word[mws2d_pkg::WIN_W-1:0];
         default: ;
      endcase
      cur_row = '0;
      cur_col = '0;
   endtask

   // drain everything, then let the pipeline settle
   task automatic wait_idle();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || expected_sums.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic run_phase(input int h, input int w, input int wr, input int wc,
                            input int grids, input int extra, input fill_kind_type fill);
      int eh, ew;
      write_reg(mws2d_pkg::CSR_GRID_HEIGHT, h);
      write_reg(mws2d_pkg::CSR_GRID_WIDTH, w);
      write_reg(mws2d_pkg::CSR_WIN_ROWS, wr);
      write_reg(mws2d_pkg::CSR_WIN_COLS, wc);
      eh = (h == 0) ? 1 : h;
      ew = (w == 0) ? 1 : ((w > mws2d_pkg::DEF_MAX_WIDTH) ? mws2d_pkg::DEF_MAX_WIDTH : w);
      repeat (grids * eh * ew + extra) cell_queue.push_back(next_sample(fill));
      wait_idle();
   endtask

   initial begin
      int h, w, wr, wc, eh, ew, grids, extra, roll, random_items;
      reset_model();
      random_items = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // one grid with the register values left by reset
      repeat (100) cell_queue.push_back(next_sample(FILL_MIXED));
      random_items += 100;
      wait_idle();

      run_phase(2, 3, 2, 2, 1, 0, FILL_MAX);
      run_phase(2, 3, 2, 2, 1, 0, FILL_MIN);      // all negative: floor holds at zero
      run_phase(2, 3, 3, 3, 1, 0, FILL_MAX);      // window taller than the grid and as wide as it
      run_phase(1, 2, 0, 1, 1, 0, FILL_MAX);      // zero window height
      run_phase(1, 2, 1, 17, 1, 0, FILL_MAX);     // window wider than the column store
      run_phase(0, 0, 1, 1, 1, 0, FILL_MAX);      // zero grid size taken as 1x1
      run_phase(2, 3, 1, 1, 0, 3, FILL_MAX);      // half a grid, then restart by a write

      // fill the block while the output is held, then pause without a write
      write_reg(mws2d_pkg::CSR_GRID_HEIGHT, 1);
      write_reg(mws2d_pkg::CSR_GRID_WIDTH, 2);
      write_reg(mws2d_pkg::CSR_WIN_ROWS, 1);
      write_reg(mws2d_pkg::CSR_WIN_COLS, 1);
      hold_requests++;
      repeat (80) cell_queue.push_back(next_sample(FILL_MIXED));
      wait_idle();
      repeat (40) cell_queue.push_back(next_sample(FILL_MIXED));
      wait_idle();

      run_phase(17, 18, 16, 16, 1, 0, FILL_MIXED);
      run_phase(2, 511, 2, 16, 1, 0, FILL_MIXED);
      run_phase(260, 1, 16, 1, 1, 0, FILL_MIXED);
      run_phase(16'hFFFF, 1, 1, 1, 0, 30, FILL_MIXED);
      random_items += 306 + 512 + 260 + 30;

      while (random_items < 1950) begin
         calm = ($urandom_range(0, 5) == 0);
         roll = $urandom_range(0, 19);
         h = (roll == 0) ? 0 : $urandom_range(1, 8);
         roll = $urandom_range(0, 19);
         if (roll == 0) w = 0;
         else if (roll == 1) w = $urandom_range(257, 511);
         else w = $urandom_range(1, 24);
         if (w > mws2d_pkg::DEF_MAX_WIDTH) h = 1;
         eh = (h == 0) ? 1 : h;
         ew = (w == 0) ? 1 : ((w > mws2d_pkg::DEF_MAX_WIDTH) ? mws2d_pkg::DEF_MAX_WIDTH : w);
         wr = pick_win(eh);
         wc = pick_win(ew);
         grids = (eh * ew > 64) ? 1 : $urandom_range(1, 3);
         extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, ew) : 0;
         run_phase(h, w, wr, wc, grids, extra, FILL_MIXED);
         random_items += grids * eh * ew + extra;
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
